// ===== src/hdms_pkg.sv =====
// Package for the hybrid drive mode selector: mode codes, register indexes,
// widths and the structs shared by the datapath modules. No dependencies.
package hdms_pkg;

  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [2:0] {
    MODE_STANDSTILL = 3'd0,
    MODE_ELECTRIC   = 3'd1,
    MODE_COMBUSTION = 3'd2,
    MODE_HYBRID     = 3'd3,
    MODE_REGEN      = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_LIMIT_EV        = 3'd0,
    CFG_SOC_THRESHOLD         = 3'd1,
    CFG_PEDAL_LIMIT_EV        = 3'd2,
    CFG_POWER_LIMIT_EV        = 3'd3,
    CFG_BRAKE_BAND            = 3'd4,
    CFG_HYBRID_ACCEL_LEVEL    = 3'd5,
    CFG_ELECTRIC_RETURN_ACCEL = 3'd6
  } cfg_idx_t;

  localparam logic [11:0]        RST_SPEED_LIMIT_EV        = 12'd480;
  localparam logic [12:0]        RST_SOC_THRESHOLD         = 13'd1516;
  localparam logic [12:0]        RST_PEDAL_LIMIT_EV        = 13'd1638;
  localparam logic signed [14:0] RST_POWER_LIMIT_EV        = 15'sd192;
  localparam logic [12:0]        RST_BRAKE_BAND            = 13'd41;
  localparam logic [12:0]        RST_HYBRID_ACCEL_LEVEL    = 13'd1638;
  localparam logic [12:0]        RST_ELECTRIC_RETURN_ACCEL = 13'd1229;

  localparam logic [12:0] TORQUE_MAX = 13'h1FFF;

  typedef struct packed {
    logic [11:0]        speed_limit_ev;
    logic [12:0]        soc_threshold;
    logic [12:0]        pedal_limit_ev;
    logic signed [14:0] power_limit_ev;
    logic [12:0]        brake_band;
    logic [12:0]        hybrid_accel_level;
    logic [12:0]        electric_return_accel;
  } cfg_t;

  typedef struct packed {
    logic signed [13:0] accel_demand;
    logic signed [13:0] brake_demand;
    logic [11:0]        vehicle_speed;
    logic [12:0]        battery_charge;
    logic [12:0]        pedal_position;
    logic signed [14:0] power_demand;
  } in_item_t;

  typedef struct packed {
    mode_t       drive_mode;
    logic        generator_enable;
    logic        motor_enable;
    logic        engine_enable;
    logic [12:0] drive_torque;
    logic [12:0] brake_torque;
  } out_item_t;

endpackage

// ===== src/hdms_in_if.sv =====
// Input channel of the drive mode selector: valid/ready plus the sensor word.
// Depends on nothing.
interface hdms_in_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] accel_demand;
  logic signed [13:0] brake_demand;
  logic [11:0]        vehicle_speed;
  logic [12:0]        battery_charge;
  logic [12:0]        pedal_position;
  logic signed [14:0] power_demand;

  modport source (output valid, accel_demand, brake_demand, vehicle_speed,
                  battery_charge, pedal_position, power_demand, input ready);
  modport sink   (input valid, accel_demand, brake_demand, vehicle_speed,
                  battery_charge, pedal_position, power_demand, output ready);
endinterface

// ===== src/hdms_out_if.sv =====
// Result channel of the drive mode selector: valid/ready plus the command word.
// Depends on nothing.
interface hdms_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  drive_mode;
  logic        generator_enable;
  logic        motor_enable;
  logic        engine_enable;
  logic [12:0] drive_torque;
  logic [12:0] brake_torque;

  modport source (output valid, drive_mode, generator_enable, motor_enable,
                  engine_enable, drive_torque, brake_torque, input ready);
  modport sink   (input valid, drive_mode, generator_enable, motor_enable,
                  engine_enable, drive_torque, brake_torque, output ready);
endinterface

// ===== src/hybrid_drive_mode_selector.sv =====
// Top level of the hybrid drive mode selector: input register, mode register
// and result register. Depends on hdms_pkg, hdms_in_if, hdms_out_if,
// hdms_cfg_regs and hdms_mode_logic.
//
// Usage:
//   in_bus  - one sensor word per control tick (accel, brake, speed, charge,
//             pedal, power), valid/ready handshake.
//   out_bus - one command word per sensor word: drive mode, generator, motor
//             and engine enables, drive and brake torque demand.
//   cfg_*   - write-only threshold registers, index 0..6; write only while idle.
// Path: a word accepted on in_bus is registered in the input register, evaluated
// against the current mode and loaded into the result register driving out_bus.
// Throughput: one word per cycle while out_bus is taken; the only loop is the
// 3-bit mode register, updated in the same cycle the result register loads.
// Reset: thresholds take their default values, mode returns to standstill and
// both pipeline stages empty.
// Stall: when out_bus is not taken, the result holds; the input register still
// accepts one more word, after which in_bus.ready drops until the result moves.
module hybrid_drive_mode_selector (
  input  logic                             clk,
  input  logic                             rst_n,
  hdms_in_if.sink                          in_bus,
  hdms_out_if.source                       out_bus,
  input  logic                             cfg_we,
  input  logic [hdms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  hdms_pkg::cfg_t      cfg;
  hdms_pkg::in_item_t  in_word, s1_r;
  hdms_pkg::out_item_t result, out_r;
  hdms_pkg::mode_t     mode_r, mode_nxt;
  logic                s1_valid_r, out_valid_r;
  logic                advance, in_ready, in_take;

  hdms_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  assign in_word.accel_demand   = in_bus.accel_demand;
  assign in_word.brake_demand   = in_bus.brake_demand;
  assign in_word.vehicle_speed  = in_bus.vehicle_speed;
  assign in_word.battery_charge = in_bus.battery_charge;
  assign in_word.pedal_position = in_bus.pedal_position;
  assign in_word.power_demand   = in_bus.power_demand;

  // Result register can load when empty or being taken this cycle.
  assign advance  = !out_valid_r || out_bus.ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_bus.valid && in_ready;
  assign in_bus.ready = in_ready;

  hdms_mode_logic u_logic (
    .cfg     (cfg),
    .item    (s1_r),
    .mode_cur(mode_r),
    .mode_nxt(mode_nxt),
    .result  (result)
  );

  // Control: stage valids and the mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= hdms_pkg::MODE_STANDSTILL;
    end else begin
      if (in_ready) s1_valid_r <= in_bus.valid;
      if (advance) begin
        out_valid_r <= s1_valid_r;
        // Advance the mode only when a word actually moves into the result.
        if (s1_valid_r) mode_r <= mode_nxt;
      end
    end
  end

  // Payload: no reset.
  always_ff @(posedge clk) begin
    if (in_take) s1_r <= in_word;
    if (advance && s1_valid_r) out_r <= result;
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.drive_mode       = out_r.drive_mode;
  assign out_bus.generator_enable = out_r.generator_enable;
  assign out_bus.motor_enable     = out_r.motor_enable;
  assign out_bus.engine_enable    = out_r.engine_enable;
  assign out_bus.drive_torque     = out_r.drive_torque;
  assign out_bus.brake_torque     = out_r.brake_torque;

  // A word waiting in the input register is never lost while the result stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("input register dropped a word during stall");

  // The mode changes only when a word moves into the result register.
  a_mode_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && advance) |=> $stable(mode_r))
    else $error("mode changed without a word advancing");

  // The presented result always carries the mode now held.
  a_mode_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.drive_mode == mode_r))
    else $error("presented mode differs from mode register");

  // Generator and engine are never commanded together.
  a_gen_eng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.generator_enable && out_r.engine_enable))
    else $error("generator and engine enabled together");

endmodule

// ===== src/hdms_cfg_regs.sv =====
// Threshold register file of the drive mode selector.
// Depends on hdms_pkg.
module hdms_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hdms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output hdms_pkg::cfg_t                   cfg
);

  hdms_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_limit_ev        <= hdms_pkg::RST_SPEED_LIMIT_EV;
      cfg_r.soc_threshold         <= hdms_pkg::RST_SOC_THRESHOLD;
      cfg_r.pedal_limit_ev        <= hdms_pkg::RST_PEDAL_LIMIT_EV;
      cfg_r.power_limit_ev        <= hdms_pkg::RST_POWER_LIMIT_EV;
      cfg_r.brake_band            <= hdms_pkg::RST_BRAKE_BAND;
      cfg_r.hybrid_accel_level    <= hdms_pkg::RST_HYBRID_ACCEL_LEVEL;
      cfg_r.electric_return_accel <= hdms_pkg::RST_ELECTRIC_RETURN_ACCEL;
    end else if (cfg_we) begin
      case (hdms_pkg::cfg_idx_t'(cfg_index))
        hdms_pkg::CFG_SPEED_LIMIT_EV:        cfg_r.speed_limit_ev <= cfg_wdata[11:0];
        hdms_pkg::CFG_SOC_THRESHOLD:         cfg_r.soc_threshold  <= cfg_wdata[12:0];
        hdms_pkg::CFG_PEDAL_LIMIT_EV:        cfg_r.pedal_limit_ev <= cfg_wdata[12:0];
        hdms_pkg::CFG_POWER_LIMIT_EV:        cfg_r.power_limit_ev <= signed'(cfg_wdata);
        hdms_pkg::CFG_BRAKE_BAND:            cfg_r.brake_band     <= cfg_wdata[12:0];
        hdms_pkg::CFG_HYBRID_ACCEL_LEVEL:    cfg_r.hybrid_accel_level <= cfg_wdata[12:0];
        hdms_pkg::CFG_ELECTRIC_RETURN_ACCEL: cfg_r.electric_return_accel <= cfg_wdata[12:0];
        default: ;  // drop writes beyond the list
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/hdms_mode_logic.sv =====
// Combinational mode update and command decode for one sensor word.
// Depends on hdms_pkg.
module hdms_mode_logic (
  input  hdms_pkg::cfg_t      cfg,
  input  hdms_pkg::in_item_t  item,
  input  hdms_pkg::mode_t     mode_cur,
  output hdms_pkg::mode_t     mode_nxt,
  output hdms_pkg::out_item_t result
);

  logic signed [15:0] acc_w, brk_w, band_w, hyb_w, ret_w;
  logic brake_on, brake_off, ev, fast, hard, low_soc, acc_pos, acc_zero, speed_zero;
  hdms_pkg::mode_t mode_mid;

  assign acc_w  = 16'(item.accel_demand);
  assign brk_w  = 16'(item.brake_demand);
  assign band_w = signed'({3'b000, cfg.brake_band});
  assign hyb_w  = signed'({3'b000, cfg.hybrid_accel_level});
  assign ret_w  = signed'({3'b000, cfg.electric_return_accel});

  assign brake_on   = brk_w < -band_w;
  assign brake_off  = brk_w > band_w;
  assign fast       = item.vehicle_speed > cfg.speed_limit_ev;
  assign low_soc    = item.battery_charge < cfg.soc_threshold;
  assign ev         = !fast && !low_soc &&
                      !(item.pedal_position > cfg.pedal_limit_ev) &&
                      !(item.power_demand > cfg.power_limit_ev);
  assign hard       = acc_w >= hyb_w;
  assign acc_pos    = item.accel_demand > 14'sd0;
  assign acc_zero   = item.accel_demand == 14'sd0;
  assign speed_zero = item.vehicle_speed == 12'd0;

  // Brake override first, then the regular transitions in the same tick.
  always_comb begin
    mode_mid = mode_cur;
    if (brake_on) begin
      mode_mid = hdms_pkg::MODE_REGEN;
    end else if (mode_cur == hdms_pkg::MODE_REGEN && brake_off) begin
      mode_mid = speed_zero ? hdms_pkg::MODE_STANDSTILL : hdms_pkg::MODE_ELECTRIC;
    end
  end

  always_comb begin
    mode_nxt = mode_mid;
    case (mode_mid)
      hdms_pkg::MODE_STANDSTILL: begin
        if (acc_pos && ev)           mode_nxt = hdms_pkg::MODE_ELECTRIC;
        else if (acc_pos && low_soc) mode_nxt = hdms_pkg::MODE_COMBUSTION;
      end
      hdms_pkg::MODE_ELECTRIC: begin
        if (speed_zero && acc_zero)         mode_nxt = hdms_pkg::MODE_STANDSTILL;
        else if (!ev)                       mode_nxt = hdms_pkg::MODE_COMBUSTION;
        else if ((hard || fast) && !low_soc) mode_nxt = hdms_pkg::MODE_HYBRID;
      end
      hdms_pkg::MODE_COMBUSTION: begin
        if (ev)                             mode_nxt = hdms_pkg::MODE_ELECTRIC;
        else if ((hard || fast) && low_soc) mode_nxt = hdms_pkg::MODE_HYBRID;
      end
      hdms_pkg::MODE_HYBRID: begin
        if (ev && (acc_w < ret_w)) mode_nxt = hdms_pkg::MODE_ELECTRIC;
        else if (low_soc)          mode_nxt = hdms_pkg::MODE_COMBUSTION;
      end
      default: ;
    endcase
  end

  always_comb begin
    result.drive_mode       = mode_nxt;
    result.generator_enable = 1'b0;
    result.motor_enable     = 1'b0;
    result.engine_enable    = 1'b0;
    case (mode_nxt)
      hdms_pkg::MODE_STANDSTILL: begin
        result.generator_enable = 1'b1;
        result.motor_enable     = 1'b1;
      end
      hdms_pkg::MODE_ELECTRIC:   result.motor_enable  = 1'b1;
      hdms_pkg::MODE_COMBUSTION: result.engine_enable = 1'b1;
      hdms_pkg::MODE_HYBRID: begin
        result.motor_enable  = 1'b1;
        result.engine_enable = 1'b1;
      end
      hdms_pkg::MODE_REGEN:      result.generator_enable = 1'b1;
      default: ;
    endcase

    result.drive_torque = acc_pos ? item.accel_demand[12:0] : 13'd0;
    // Full-scale negative brake would need 14 bits; saturate it.
    if (item.brake_demand == -14'sd8192)
      result.brake_torque = hdms_pkg::TORQUE_MAX;
    else if (item.brake_demand < 14'sd0)
      result.brake_torque = 13'(-brk_w);
    else
      result.brake_torque = 13'd0;
  end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for hybrid_drive_mode_selector: directed table plus
// biased random words, checked against an in-bench mode predictor.
// Depends on hdms_pkg, hdms_in_if, hdms_out_if and the block itself.
module tb;

  localparam int QUIET_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int HOLD_CYCLES = 70;    // long sink hold-off, forces in_bus to stall
  localparam int RAND_WORDS  = 125;   // random words per threshold setting
  localparam int N_SETTINGS  = 8;
  localparam logic [hdms_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  typedef struct {
    hdms_pkg::in_item_t  w;
    bit                  typed;
    hdms_pkg::out_item_t cmd;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [hdms_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hdms_pkg::CFG_DATA_W-1:0] cfg_wdata;

  hdms_in_if  in_ch ();
  hdms_out_if out_ch ();

  hybrid_drive_mode_selector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_ch),
    .out_bus   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block: thresholds and the mode register.
  hdms_pkg::cfg_t      thr;
  hdms_pkg::mode_t     mode_q;
  hdms_pkg::out_item_t pending_cmds[$];

  int  errors;
  int  words_seen;
  int  quiet;
  int  hold_left;
  bit  hold_req;
  bit  send_gaps;
  bit  sink_stalls;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mirror one register write into the shadow thresholds; unknown indexes drop.
  function automatic void apply_threshold(logic [hdms_pkg::CFG_IDX_W-1:0] idx,
                                          logic [hdms_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      hdms_pkg::CFG_SPEED_LIMIT_EV:        thr.speed_limit_ev = v[11:0];
      hdms_pkg::CFG_SOC_THRESHOLD:         thr.soc_threshold = v[12:0];
      hdms_pkg::CFG_PEDAL_LIMIT_EV:        thr.pedal_limit_ev = v[12:0];
      hdms_pkg::CFG_POWER_LIMIT_EV:        thr.power_limit_ev = v;
      hdms_pkg::CFG_BRAKE_BAND:            thr.brake_band = v[12:0];
      hdms_pkg::CFG_HYBRID_ACCEL_LEVEL:    thr.hybrid_accel_level = v[12:0];
      hdms_pkg::CFG_ELECTRIC_RETURN_ACCEL: thr.electric_return_accel = v[12:0];
      default: ;
    endcase
  endfunction

  // Compute the command word for one sensor word and advance the shadow mode.
  function automatic hdms_pkg::out_item_t decide_mode_cmd(hdms_pkg::in_item_t w);
    hdms_pkg::out_item_t c;
    int  acc    = int'(w.accel_demand);
    int  brk    = int'(w.brake_demand);
    int  speed  = int'(w.vehicle_speed);
    int  charge = int'(w.battery_charge);
    int  pedal  = int'(w.pedal_position);
    int  power  = int'(w.power_demand);
    int  band   = int'(thr.brake_band);
    int  soc    = int'(thr.soc_threshold);
    bit  fast   = speed > int'(thr.speed_limit_ev);
    bit  hard   = acc >= int'(thr.hybrid_accel_level);
    bit  ev     = !fast && charge >= soc && pedal <= int'(thr.pedal_limit_ev) &&
                  power <= int'(thr.power_limit_ev);
    hdms_pkg::mode_t m = mode_q;
    int  bt;

    // Brake pedal first: pressing past the band forces regen, releasing leaves it.
    if (brk < -band)
      m = hdms_pkg::MODE_REGEN;
    else if (m == hdms_pkg::MODE_REGEN && brk > band)
      m = (speed == 0) ? hdms_pkg::MODE_STANDSTILL : hdms_pkg::MODE_ELECTRIC;

    case (m)
      hdms_pkg::MODE_STANDSTILL: begin
        if (acc > 0 && ev) m = hdms_pkg::MODE_ELECTRIC;
        else if (acc > 0 && charge < soc) m = hdms_pkg::MODE_COMBUSTION;
      end
      hdms_pkg::MODE_ELECTRIC: begin
        if (speed == 0 && acc == 0) m = hdms_pkg::MODE_STANDSTILL;
        else if (!ev) m = hdms_pkg::MODE_COMBUSTION;
        else if ((hard || fast) && charge >= soc) m = hdms_pkg::MODE_HYBRID;
      end
      hdms_pkg::MODE_COMBUSTION: begin
        if (ev) m = hdms_pkg::MODE_ELECTRIC;
        else if ((hard || fast) && charge < soc) m = hdms_pkg::MODE_HYBRID;
      end
      hdms_pkg::MODE_HYBRID: begin
        if (ev && acc < int'(thr.electric_return_accel)) m = hdms_pkg::MODE_ELECTRIC;
        else if (charge < soc) m = hdms_pkg::MODE_COMBUSTION;
      end
      default: ;
    endcase
    mode_q = m;

    c.drive_mode       = m;
    c.generator_enable = (m == hdms_pkg::MODE_STANDSTILL || m == hdms_pkg::MODE_REGEN);
    c.motor_enable     = (m == hdms_pkg::MODE_STANDSTILL || m == hdms_pkg::MODE_ELECTRIC ||
                          m == hdms_pkg::MODE_HYBRID);
    c.engine_enable    = (m == hdms_pkg::MODE_COMBUSTION || m == hdms_pkg::MODE_HYBRID);
    c.drive_torque     = (acc > 0) ? acc[12:0] : 13'd0;
    // Full-scale braking would need 8192; the torque field saturates.
    bt = (brk < 0) ? -brk : 0;
    c.brake_torque     = (bt > 8191) ? hdms_pkg::TORQUE_MAX : bt[12:0];
    return c;
  endfunction

  function automatic int near(int center, int lo, int hi);
    int v = center + int'($urandom_range(0, 16)) - 8;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Random sensor word, partly clustered around the live thresholds so the
  // mode machine keeps crossing its boundaries; a tenth of each field is raw noise.
  function automatic hdms_pkg::in_item_t gen_word();
    hdms_pkg::in_item_t w;
    int band = int'(thr.brake_band);
    int r;

    r = int'($urandom_range(99));
    if (r < 10)      w.accel_demand = 14'($urandom);
    else if (r < 25) w.accel_demand = '0;
    else if (r < 40)
      w.accel_demand = 14'(near(int'(thr.hybrid_accel_level), -8192, 8191));
    else if (r < 55)
      w.accel_demand = 14'(near(int'(thr.electric_return_accel), -8192, 8191));
    else             w.accel_demand = 14'($urandom_range(0, 4096));

    // Keep the brake inside the band most of the time so regen spells last a
    // while, with occasional presses and releases just past it.
    r = int'($urandom_range(99));
    if (r < 10)      w.brake_demand = 14'($urandom);
    else if (r < 70) w.brake_demand = 14'(int'($urandom_range(0, 2 * band)) - band);
    else if (r < 85) w.brake_demand = 14'(near(-band - 9, -8192, 8191));
    else             w.brake_demand = 14'(near(band + 9, -8192, 8191));

    r = int'($urandom_range(99));
    if (r < 10)      w.vehicle_speed = 12'($urandom);
    else if (r < 25) w.vehicle_speed = '0;
    else if (r < 60) w.vehicle_speed = 12'(near(int'(thr.speed_limit_ev), 0, 4095));
    else             w.vehicle_speed = 12'($urandom_range(0, 1000));

    r = int'($urandom_range(99));
    if (r < 10)      w.battery_charge = 13'($urandom);
    else if (r < 50) w.battery_charge = 13'(near(int'(thr.soc_threshold), 0, 8191));
    else             w.battery_charge = 13'($urandom_range(0, 4096));

    r = int'($urandom_range(99));
    if (r < 10)      w.pedal_position = 13'($urandom);
    else if (r < 45) w.pedal_position = 13'(near(int'(thr.pedal_limit_ev), 0, 8191));
    else             w.pedal_position = 13'($urandom_range(0, int'(thr.pedal_limit_ev)));

    r = int'($urandom_range(99));
    if (r < 10)      w.power_demand = 15'($urandom);
    else if (r < 45)
      w.power_demand = 15'(near(int'(thr.power_limit_ev), -16384, 16383));
    else             w.power_demand = 15'(int'($urandom_range(0, 400)) - 200);
    return w;
  endfunction

  function automatic dir_row_t mk_row(int acc, int brk, int spd, int chg, int ped,
                                      int pwr, bit typed, hdms_pkg::mode_t m, bit g,
                                      bit mo, bit e, int dt, int bt);
    dir_row_t row;
    row.w.accel_demand         = 14'(acc);
    row.w.brake_demand         = 14'(brk);
    row.w.vehicle_speed        = 12'(spd);
    row.w.battery_charge       = 13'(chg);
    row.w.pedal_position       = 13'(ped);
    row.w.power_demand         = 15'(pwr);
    row.typed                  = typed;
    row.cmd.drive_mode         = m;
    row.cmd.generator_enable   = g;
    row.cmd.motor_enable       = mo;
    row.cmd.engine_enable      = e;
    row.cmd.drive_torque       = 13'(dt);
    row.cmd.brake_torque       = 13'(bt);
    return row;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH word %0d: %s got %0d expected %0d", words_seen, what, got, want);
  endtask

  // Offer one sensor word; called and returns on a falling edge.
  task automatic send_word(hdms_pkg::in_item_t w, bit typed,
                           hdms_pkg::out_item_t typed_cmd);
    hdms_pkg::out_item_t c;
    while (send_gaps && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.accel_demand   <= w.accel_demand;
    in_ch.brake_demand   <= w.brake_demand;
    in_ch.vehicle_speed  <= w.vehicle_speed;
    in_ch.battery_charge <= w.battery_charge;
    in_ch.pedal_position <= w.pedal_position;
    in_ch.power_demand   <= w.power_demand;
    do @(posedge clk); while (!in_ch.ready);
    // Always run the predictor so the shadow mode stays in step, even when
    // the row carries a hand-typed command.
    c = decide_mode_cmd(w);
    pending_cmds.push_back(typed ? typed_cmd : c);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [hdms_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[hdms_pkg::CFG_DATA_W-1:0];
    apply_threshold(idx, val[hdms_pkg::CFG_DATA_W-1:0]);
    @(negedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it.
  task automatic program_thresholds(int sp, int soc, int ped, int pwr, int band,
                                    int hyb, int ret);
    write_reg(hdms_pkg::CFG_SPEED_LIMIT_EV, sp);
    write_reg(hdms_pkg::CFG_SOC_THRESHOLD, soc);
    write_reg(hdms_pkg::CFG_PEDAL_LIMIT_EV, ped);
    write_reg(hdms_pkg::CFG_POWER_LIMIT_EV, pwr);
    write_reg(hdms_pkg::CFG_BRAKE_BAND, band);
    write_reg(hdms_pkg::CFG_HYBRID_ACCEL_LEVEL, hyb);
    write_reg(hdms_pkg::CFG_ELECTRIC_RETURN_ACCEL, ret);
  endtask

  // Drain: drop valid, wait for every command word, then cover the pipeline.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sink side: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(sink_stalls && $urandom_range(99) < 27);
      end
    end
  end

  // Check each accepted command word against the oldest prediction.
  always @(posedge clk) begin : cmd_check
    hdms_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected word, drive_mode", int'(out_ch.drive_mode), -1);
      end else begin
        want = pending_cmds.pop_front();
        if (out_ch.drive_mode !== want.drive_mode)
          report_mismatch("drive_mode", int'(out_ch.drive_mode), int'(want.drive_mode));
        if (out_ch.generator_enable !== want.generator_enable)
          report_mismatch("generator_enable", int'(out_ch.generator_enable),
                          int'(want.generator_enable));
        if (out_ch.motor_enable !== want.motor_enable)
          report_mismatch("motor_enable", int'(out_ch.motor_enable),
                          int'(want.motor_enable));
        if (out_ch.engine_enable !== want.engine_enable)
          report_mismatch("engine_enable", int'(out_ch.engine_enable),
                          int'(want.engine_enable));
        if (out_ch.drive_torque !== want.drive_torque)
          report_mismatch("drive_torque", int'(out_ch.drive_torque),
                          int'(want.drive_torque));
        if (out_ch.brake_torque !== want.brake_torque)
          report_mismatch("brake_torque", int'(out_ch.brake_torque),
                          int'(want.brake_torque));
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet++;
    end
  end

  initial begin : stimulus
    dir_row_t            rows[$];
    hdms_pkg::out_item_t no_cmd;
    int                  phase;
    int                  k;
    int                  hyb;

    no_cmd      = '0;
    errors      = 0;
    words_seen  = 0;
    quiet       = 0;
    hold_left   = 0;
    hold_req    = 1'b0;
    send_gaps   = 1'b1;
    sink_stalls = 1'b1;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.accel_demand   <= '0;
    in_ch.brake_demand   <= '0;
    in_ch.vehicle_speed  <= '0;
    in_ch.battery_charge <= '0;
    in_ch.pedal_position <= '0;
    in_ch.power_demand   <= '0;

    // Shadow state after reset.
    thr.speed_limit_ev        = hdms_pkg::RST_SPEED_LIMIT_EV;
    thr.soc_threshold         = hdms_pkg::RST_SOC_THRESHOLD;
    thr.pedal_limit_ev        = hdms_pkg::RST_PEDAL_LIMIT_EV;
    thr.power_limit_ev        = hdms_pkg::RST_POWER_LIMIT_EV;
    thr.brake_band            = hdms_pkg::RST_BRAKE_BAND;
    thr.hybrid_accel_level    = hdms_pkg::RST_HYBRID_ACCEL_LEVEL;
    thr.electric_return_accel = hdms_pkg::RST_ELECTRIC_RETURN_ACCEL;
    mode_q                    = hdms_pkg::MODE_STANDSTILL;

    // Directed walk under reset thresholds. Columns: accel, brake, speed,
    // charge, pedal, power | typed?, mode, gen, motor, engine, drive, brake torque.
    rows.push_back(mk_row(    0,     0,    0, 4096,    0,      0,
                          1, hdms_pkg::MODE_STANDSTILL, 1, 1, 0,    0,    0));
    rows.push_back(mk_row(  819,     0,  100, 4096,  500,    100,
                          1, hdms_pkg::MODE_ELECTRIC,   0, 1, 0,  819,    0));
    rows.push_back(mk_row( 2000,     0,  100, 4096,  500,    100,
                          0, hdms_pkg::MODE_STANDSTILL, 0, 0, 0,    0,    0));
    rows.push_back(mk_row( 2000,     0,  100, 1000,  500,    100,
                          0, hdms_pkg::MODE_STANDSTILL, 0, 0, 0,    0,    0));
    rows.push_back(mk_row( 1000,     0,  100, 4096,  500,    100,
                          0, hdms_pkg::MODE_STANDSTILL, 0, 0, 0,    0,    0));
    // Power at its top code bars electric.
    rows.push_back(mk_row( 1000,     0,  100, 4096,  500,  16383,
                          1, hdms_pkg::MODE_COMBUSTION, 0, 0, 1, 1000,    0));
    rows.push_back(mk_row( 8191,  8191, 4095,    0,  500,    100,
                          1, hdms_pkg::MODE_HYBRID,     0, 1, 1, 8191,    0));
    // Full braking: regen, brake torque saturates.
    rows.push_back(mk_row(-8192, -8192, 4095,    0,  500,    100,
                          1, hdms_pkg::MODE_REGEN,      1, 0, 0,    0, 8191));
    // Brake exactly on either edge of the dead band: stay in regen.
    rows.push_back(mk_row(    0,   -41,  100, 4096,    0,      0,
                          1, hdms_pkg::MODE_REGEN,      1, 0, 0,    0,   41));
    rows.push_back(mk_row(    0,    41,  100, 4096,    0,      0,
                          1, hdms_pkg::MODE_REGEN,      1, 0, 0,    0,    0));
    // Release past the band at zero speed: back to standstill.
    rows.push_back(mk_row(    0,    42,    0, 4096,    0,      0,
                          1, hdms_pkg::MODE_STANDSTILL, 1, 1, 0,    0,    0));
    rows.push_back(mk_row(   50,     0,    0, 4096, 8191,      0,
                          1, hdms_pkg::MODE_STANDSTILL, 1, 1, 0,   50,    0));
    rows.push_back(mk_row(    0,   -42,  200, 4096,    0,      0,
                          1, hdms_pkg::MODE_REGEN,      1, 0, 0,    0,   42));
    // Release while rolling: electric, then same-tick transitions apply.
    rows.push_back(mk_row(  500,    42,  200, 4096,    0,      0,
                          0, hdms_pkg::MODE_STANDSTILL, 0, 0, 0,    0,    0));
    rows.push_back(mk_row(    0,     0,    0, 4096,    0,      0,
                          1, hdms_pkg::MODE_STANDSTILL, 1, 1, 0,    0,    0));
    rows.push_back(mk_row(  100,     0,    0, 1000,    0,      0,
                          1, hdms_pkg::MODE_COMBUSTION, 0, 0, 1,  100,    0));
    rows.push_back(mk_row(    0,     0,    0, 4096,    0, -16384,
                          1, hdms_pkg::MODE_ELECTRIC,   0, 1, 0,    0,    0));
    rows.push_back(mk_row(   10,     0,    0, 4096, 8191,      0,
                          1, hdms_pkg::MODE_COMBUSTION, 0, 0, 1,   10,    0));
    rows.push_back(mk_row( 4096,     0,    0, 8191, 8191,      0,
                          1, hdms_pkg::MODE_COMBUSTION, 0, 0, 1, 4096,    0));
    rows.push_back(mk_row(   -1,    -1,    0, 4096,    0,      0,
                          0, hdms_pkg::MODE_STANDSTILL, 0, 0, 0,    0,    0));

    // Hold reset, then release it on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < N_SETTINGS; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: program_thresholds(0, 0, 0, -16384, 0, 0, 0);
          2: begin
            program_thresholds(4095, 8191, 8191, 16383, 8191, 8191, 8191);
            // An index past the register list must change nothing.
            write_reg(CFG_IDX_UNUSED, 0);
          end
          N_SETTINGS - 1:
            program_thresholds(int'(hdms_pkg::RST_SPEED_LIMIT_EV),
                               int'(hdms_pkg::RST_SOC_THRESHOLD),
                               int'(hdms_pkg::RST_PEDAL_LIMIT_EV),
                               int'(hdms_pkg::RST_POWER_LIMIT_EV),
                               int'(hdms_pkg::RST_BRAKE_BAND),
                               int'(hdms_pkg::RST_HYBRID_ACCEL_LEVEL),
                               int'(hdms_pkg::RST_ELECTRIC_RETURN_ACCEL));
          default: begin
            hyb = int'($urandom_range(500, 3500));
            program_thresholds(int'($urandom_range(100, 1000)),
                               int'($urandom_range(500, 3500)),
                               int'($urandom_range(500, 3500)),
                               int'($urandom_range(0, 1100)) - 100,
                               int'($urandom_range(0, 300)), hyb,
                               int'($urandom_range(0, hyb)));
          end
        endcase
        cfg_we <= 1'b0;
      end

      // One setting runs with no idling on either side.
      send_gaps   = (phase != 2);
      sink_stalls = (phase != 2);

      if (phase == 0)
        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].cmd);

      for (k = 0; k < RAND_WORDS; k++) begin
        // Hold the sink off while words keep coming, so in_bus must stall.
        if (phase == 1 && k == 30) hold_req = 1'b1;
        send_word(gen_word(), 1'b0, no_cmd);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== hybrid_drive_mode_selector.f =====
src/hdms_pkg.sv
src/hdms_in_if.sv
src/hdms_out_if.sv
src/hdms_cfg_regs.sv
src/hdms_mode_logic.sv
src/hybrid_drive_mode_selector.sv
dv/tb.sv
